// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define SF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/sflg_pkg.sv -----
package sflg_pkg;

    localparam int DelayDepthDef  = 2048;
    localparam int SineEntriesDef = 256;

    localparam logic [2:0] CFG_HP_COEFF = 3'd0;
    localparam logic [2:0] CFG_PHASE    = 3'd1;
    localparam logic [2:0] CFG_OFFSET   = 3'd2;
    localparam logic [2:0] CFG_SWEEP    = 3'd3;
    localparam logic [2:0] CFG_MIX      = 3'd4;
    localparam logic [2:0] CFG_FEEDBACK = 3'd5;
    localparam logic [2:0] CFG_WAVE     = 3'd6;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_SQUARE = 3'd1;
    localparam logic [2:0] WAVE_FALL   = 3'd2;
    localparam logic [2:0] WAVE_RISE   = 3'd3;
    localparam logic [2:0] WAVE_TRI    = 3'd4;
    localparam logic [2:0] WAVE_RAND   = 3'd5;

    typedef struct packed {
        logic [16:0] hp_coeff;
        logic [23:0] phase_step;
        logic [23:0] stereo_offset;
        logic [18:0] sweep_samples;
        logic [15:0] mix_depth;
        logic signed [15:0] feedback;
        logic [2:0]  wave_select;
    } cfg_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Arithmetic shift right with round half up
    function automatic logic signed [47:0] rshift(input logic signed [47:0] v,
                                                 input int unsigned s);
        logic signed [47:0] t;
        t = v + (48'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

endpackage

// ----- rtl/sflg_lfo.sv -----
// Wave generator: phase to unsigned Q1.16 LFO value, sine through a multi-cycle polynomial
module sflg_lfo import sflg_pkg::*; #(
    parameter int SINE_ENTRIES = SineEntriesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [2:0]  wave,
    input  logic [23:0] phase,
    output logic        done,
    output logic [16:0] value
);
    localparam int SB = $clog2(SINE_ENTRIES);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_POLY = 3'd1;
    localparam logic [2:0] L_MUL  = 3'd2;
    localparam logic [2:0] L_DONE = 3'd3;

    logic [2:0]  st_reg, st_next;
    logic [2:0]  step_reg, step_next;
    logic [31:0] s_reg, s_next;
    logic [30:0] z_reg, z_next;
    logic [30:0] z2_reg, z2_next;
    logic        neg_reg, neg_next;
    logic [16:0] val_reg, val_next;

    logic [23:0] pq;
    logic [22:0] t;
    logic [30:0] zc;
    logic [61:0] zsq;
    logic [63:0] prod;
    logic [31:0] coef;
    logic [31:0] s_fin;
    logic [16:0] half;

    always_comb begin
        pq = phase;
        if (SB < 24) pq = {phase[23 -: SB], {(24 - SB){1'b0}}};
        t = pq[22:0];
        // fold the second quarter of each half cycle back onto the first
        if (t > 23'h400000) t = 23'(24'h800000 - 24'(t));
        zc = {t, 8'd0};
        zsq = 62'(zc) * 62'(zc);
        unique case (step_reg)
            3'd0: coef = 32'd5026995;
            3'd1: coef = 32'd85569306;
            3'd2: coef = 32'd693598669;
            default: coef = 32'd1686629713;
        endcase
        prod = (st_reg == L_MUL) ? 64'(s_reg) * 64'(z_reg) : 64'(s_reg) * 64'(z2_reg);
        s_fin = 32'(prod >> 30);
        if (s_fin > 32'h4000_0000) s_fin = 32'h4000_0000;
        half = 17'((s_fin + 32'd16384) >> 15);
    end

    always_comb begin
        st_next = st_reg;
        step_next = step_reg;
        s_next = s_reg;
        z_next = z_reg;
        z2_next = z2_reg;
        neg_next = neg_reg;
        val_next = val_reg;
        unique case (st_reg)
            L_IDLE: begin
                if (start) begin
                    st_next = L_DONE;
                    unique case (wave)
                        WAVE_SINE: begin
                            z_next = zc;
                            z2_next = 31'(zsq >> 30);
                            s_next = 32'd172272;
                            neg_next = pq[23];
                            step_next = 3'd0;
                            st_next = L_POLY;
                        end
                        WAVE_SQUARE: val_next = (phase == 24'd0) ? 17'd32768 :
                                                (!phase[23] ? 17'd65536 : 17'd0);
                        WAVE_FALL: val_next = 17'd65536 - 17'(phase[23:8]);
                        WAVE_RISE: val_next = 17'(phase[23:8]);
                        WAVE_TRI: val_next = !phase[23] ? 17'(phase[23:7]) :
                                            17'((25'h1000000 - 25'(phase)) >> 7);
                        default: val_next = 17'd0;
                    endcase
                end
            end
            L_POLY: begin
                s_next = coef - 32'(prod >> 30);
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) st_next = L_MUL;
            end
            L_MUL: begin
                val_next = neg_reg ? 17'd32768 - half : 17'd32768 + half;
                st_next = L_DONE;
            end
            L_DONE: st_next = L_IDLE;
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= L_IDLE;
        end else begin
            st_reg <= st_next;
        end
        step_reg <= step_next;
        s_reg <= s_next;
        z_reg <= z_next;
        z2_reg <= z2_next;
        neg_reg <= neg_next;
        val_reg <= val_next;
    end

    assign done = (st_reg == L_DONE);
    assign value = val_reg;
endmodule

// ----- rtl/sflg_line.sv -----
// One delay line: memory, three-tap read, quadratic interpolation, write back
module sflg_line import sflg_pkg::*; #(
    parameter int DELAY_DEPTH = DelayDepthDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               clr,
    input  logic [16:0]        w,
    input  logic [18:0]        sweep,
    input  logic [$clog2(DELAY_DEPTH)-1:0] widx,
    input  logic signed [15:0] filt,
    input  logic signed [15:0] fb,
    output logic               done,
    output logic signed [15:0] y
);
    localparam int AB = $clog2(DELAY_DEPTH);
    localparam int RB = AB + 8;
    localparam logic [18:0] Lim = 19'((DELAY_DEPTH - 8) * 256);
    localparam logic [RB-1:0] Base = RB'((DELAY_DEPTH - 4) * 256);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_POS  = 3'd1;
    localparam logic [2:0] D_RD   = 3'd2;
    localparam logic [2:0] D_INT  = 3'd3;
    localparam logic [2:0] D_WR   = 3'd4;
    localparam logic [2:0] D_DONE = 3'd5;

    logic signed [15:0] mem [DELAY_DEPTH];
    logic signed [15:0] rdata_reg;
    logic [AB-1:0] raddr;
    logic          wen;
    logic signed [15:0] wdata;

    logic [2:0] st_reg, st_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [35:0] dprod_reg;
    logic [AB-1:0] i_reg, i_next;
    logic [7:0] q_reg, q_next;
    logic signed [15:0] y0_reg, y1_reg, ym_reg;
    logic signed [15:0] y0_next, y1_next, ym_next;
    logic signed [15:0] y_reg, y_next;

    logic [18:0] sw;
    logic [19:0] d;
    logic [RB-1:0] r;
    logic signed [47:0] num;

    always_comb begin
        sw = (sweep > Lim) ? Lim : sweep;
        d = 20'((dprod_reg + 36'd32768) >> 16);
        r = RB'({widx, 8'd0}) + Base - RB'(d);
        num = (48'sd131072 * 48'(y0_reg))
            + 48'(signed'({1'b0, q_reg})) * 48'sd256 * (48'(y1_reg) - 48'(ym_reg))
            + 48'(signed'({1'b0, q_reg})) * 48'(signed'({1'b0, q_reg}))
              * (48'(y1_reg) - 48'sd2 * 48'(y0_reg) + 48'(ym_reg));
    end

    always_comb begin
        unique case (cnt_reg)
            2'd0: raddr = i_reg;
            2'd1: raddr = i_reg + AB'(1);
            default: raddr = i_reg - AB'(1);
        endcase
        // the clearing pass writes zero at widx
        wen = (st_reg == D_WR) || clr;
        wdata = clr ? 16'sd0 : sat16(48'(filt) + rshift(48'(y_reg) * 48'(fb), 15));
    end

    always_comb begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        q_next = q_reg;
        y0_next = y0_reg;
        y1_next = y1_reg;
        ym_next = ym_reg;
        y_next = y_reg;
        unique case (st_reg)
            D_IDLE: if (start) st_next = D_POS;
            D_POS: begin
                i_next = r[RB-1:8];
                q_next = r[7:0];
                cnt_next = 2'd0;
                st_next = D_RD;
            end
            D_RD: begin
                // rdata_reg holds the data of the address given in the previous cycle
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) st_next = D_INT;
            end
            D_INT: begin
                y_next = sat16(rshift(num, 17));
                st_next = D_WR;
            end
            D_WR: st_next = D_DONE;
            D_DONE: st_next = D_IDLE;
            default: st_next = D_IDLE;
        endcase
        if (st_reg == D_RD) begin
            if (cnt_reg == 2'd1) y0_next = rdata_reg;
            if (cnt_reg == 2'd2) y1_next = rdata_reg;
            if (cnt_reg == 2'd3) ym_next = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wen) mem[widx] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= D_IDLE;
        end else begin
            st_reg <= st_next;
        end
        cnt_reg <= cnt_next;
        dprod_reg <= 36'(sw) * 36'(w);
        i_reg <= i_next;
        q_reg <= q_next;
        y0_reg <= y0_next;
        y1_reg <= y1_next;
        ym_reg <= ym_next;
        y_reg <= y_next;
    end

    assign done = (st_reg == D_DONE);
    assign y = y_reg;
endmodule

// ----- rtl/stereo_flanger.sv -----
// Per item: for every wave but the random one the LFO runs twice, left phase then phase
// plus stereo offset (the sine through its polynomial steps), then both delay lines run,
// then T_OUT registers the outputs. One item in work at a time; no sample is accepted
// until the last output is taken.
// Reset (aresetn low, synchronous): registers to defaults, state cleared; the delay
// memories are then zeroed entry by entry, during which no item is accepted.
module stereo_flanger import sflg_pkg::*; #(
    parameter int DELAY_DEPTH  = DelayDepthDef,
    parameter int SINE_ENTRIES = SineEntriesDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_left,
    output logic signed [15:0] m_out_right,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    `include "assert_macros.svh"

    localparam int AB = $clog2(DELAY_DEPTH);

    localparam logic [2:0] T_CLR  = 3'd0;
    localparam logic [2:0] T_IDLE = 3'd1;
    localparam logic [2:0] T_LFO  = 3'd2;
    localparam logic [2:0] T_LINE = 3'd3;
    localparam logic [2:0] T_OUT  = 3'd4;

    cfg_t cfg_reg;
    logic [2:0] st_reg, st_next;
    logic [AB-1:0] widx_reg;
    logic [AB:0] clr_reg;
    logic signed [15:0] x_reg, hp_in_reg, hp_out_reg, filt_reg;
    logic [23:0] phase_reg;
    logic [15:0] lfsr_reg;
    logic [31:0] rpair_reg;
    logic wrap_reg;
    logic [23:0] frozen_reg;
    logic [16:0] wl_reg, wr_reg;
    logic lfo_phase_reg;
    logic lfo_go_reg, line_go_reg;
    logic signed [15:0] ol_reg, or_reg;
    logic ovalid_reg;

    logic lfo_done, dl_done, dr_done;
    logic [16:0] lfo_val;
    logic signed [15:0] yl, yr;
    logic [16:0] alpha;
    logic [15:0] mix;
    logic signed [15:0] filt_c;
    logic [15:0] l1, l2;
    logic [31:0] pair_c;
    logic [16:0] o;
    logic [16:0] wr_rand;
    logic [23:0] frozen_c;

    assign cfg_ready = 1'b1;
    assign s_ready = (st_reg == T_IDLE) && !ovalid_reg;
    assign m_valid = ovalid_reg;
    assign m_out_left = ol_reg;
    assign m_out_right = or_reg;

    function automatic logic [15:0] lstep(input logic [15:0] v);
        return v[0] ? ((v >> 1) ^ 16'hB400) : (v >> 1);
    endfunction

    always_comb begin
        alpha = (cfg_reg.hp_coeff > 17'd65536) ? 17'd65536 : cfg_reg.hp_coeff;
        mix = (cfg_reg.mix_depth > 16'd32768) ? 16'd32768 : cfg_reg.mix_depth;
        filt_c = sat16(rshift((48'(hp_out_reg) + 48'(s_sample_in) - 48'(hp_in_reg))
                              * 48'(signed'({1'b0, alpha})), 16));
        l1 = lstep(lfsr_reg);
        l2 = lstep(l1);
        pair_c = wrap_reg ? {l2, l1} : rpair_reg;
        frozen_c = wrap_reg ? cfg_reg.stereo_offset : frozen_reg;
        o = (cfg_reg.stereo_offset != 24'd0) ? 17'(frozen_c[23:8]) : 17'd0;
        wr_rand = 17'((34'(17'd65536 - o) * 34'(pair_c[15:0])
                      + 34'(o) * 34'(pair_c[31:16]) + 34'd32768) >> 16);
    end

    sflg_lfo #(.SINE_ENTRIES(SINE_ENTRIES)) u_lfo (
        .aclk(aclk), .aresetn(aresetn), .start(lfo_go_reg),
        .wave(cfg_reg.wave_select),
        .phase(lfo_phase_reg ? 24'(phase_reg + cfg_reg.stereo_offset) : phase_reg),
        .done(lfo_done), .value(lfo_val)
    );

    sflg_line #(.DELAY_DEPTH(DELAY_DEPTH)) u_left (
        .aclk(aclk), .aresetn(aresetn), .start(line_go_reg), .clr(st_reg == T_CLR),
        .w(wl_reg), .sweep(cfg_reg.sweep_samples),
        .widx(st_reg == T_CLR ? clr_reg[AB-1:0] : widx_reg),
        .filt(filt_reg), .fb(cfg_reg.feedback),
        .done(dl_done), .y(yl)
    );

    sflg_line #(.DELAY_DEPTH(DELAY_DEPTH)) u_right (
        .aclk(aclk), .aresetn(aresetn), .start(line_go_reg), .clr(st_reg == T_CLR),
        .w(wr_reg), .sweep(cfg_reg.sweep_samples),
        .widx(st_reg == T_CLR ? clr_reg[AB-1:0] : widx_reg),
        .filt(filt_reg), .fb(cfg_reg.feedback),
        .done(dr_done), .y(yr)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            T_CLR: if (clr_reg[AB]) st_next = T_IDLE;
            T_IDLE: if (s_valid && s_ready) st_next = T_LFO;
            T_LFO: if ((cfg_reg.wave_select == WAVE_RAND || lfo_done) && lfo_phase_reg)
                st_next = T_LINE;
            T_LINE: if (dl_done) st_next = T_OUT;
            T_OUT: st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= T_CLR;
            clr_reg <= '0;
            cfg_reg <= '{hp_coeff: 17'd65536, default: '0};
            widx_reg <= '0;
            hp_in_reg <= '0;
            hp_out_reg <= '0;
            phase_reg <= '0;
            lfsr_reg <= 16'hACE1;
            rpair_reg <= '0;
            wrap_reg <= 1'b0;
            frozen_reg <= '0;
            ovalid_reg <= 1'b0;
            lfo_go_reg <= 1'b0;
            line_go_reg <= 1'b0;
            lfo_phase_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            lfo_go_reg <= 1'b0;
            line_go_reg <= 1'b0;
            if (st_reg == T_CLR) begin
                // zero both lines through the write path, one entry a cycle
                clr_reg <= clr_reg + (AB + 1)'(1);
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_HP_COEFF: cfg_reg.hp_coeff <= cfg_data[16:0];
                    CFG_PHASE: cfg_reg.phase_step <= cfg_data[23:0];
                    CFG_OFFSET: cfg_reg.stereo_offset <= cfg_data[23:0];
                    CFG_SWEEP: cfg_reg.sweep_samples <= cfg_data[18:0];
                    CFG_MIX: cfg_reg.mix_depth <= cfg_data[15:0];
                    CFG_FEEDBACK: cfg_reg.feedback <= cfg_data[15:0];
                    CFG_WAVE: cfg_reg.wave_select <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                x_reg <= s_sample_in;
                filt_reg <= filt_c;
                hp_in_reg <= s_sample_in;
                hp_out_reg <= filt_c;
                lfo_phase_reg <= 1'b0;
                if (cfg_reg.wave_select == WAVE_RAND) begin
                    if (wrap_reg) lfsr_reg <= l2;
                    rpair_reg <= pair_c;
                    frozen_reg <= frozen_c;
                    wl_reg <= 17'(pair_c[15:0]);
                    wr_reg <= wr_rand;
                end else begin
                    lfo_go_reg <= 1'b1;
                end
            end
            if (st_reg == T_LFO) begin
                if (cfg_reg.wave_select == WAVE_RAND) begin
                    lfo_phase_reg <= 1'b1;
                    if (lfo_phase_reg) line_go_reg <= 1'b1;
                end else if (lfo_done) begin
                    if (!lfo_phase_reg) begin
                        wl_reg <= lfo_val;
                        lfo_phase_reg <= 1'b1;
                        lfo_go_reg <= 1'b1;
                    end else begin
                        wr_reg <= lfo_val;
                        line_go_reg <= 1'b1;
                    end
                end
            end
            if (st_reg == T_OUT) begin
                ol_reg <= sat16(48'(x_reg) + rshift(48'(yl) * 48'(signed'({1'b0, mix})), 15));
                or_reg <= sat16(48'(x_reg) + rshift(48'(yr) * 48'(signed'({1'b0, mix})), 15));
                ovalid_reg <= 1'b1;
                widx_reg <= widx_reg + AB'(1);
                {wrap_reg, phase_reg} <= 25'(phase_reg) + 25'(cfg_reg.phase_step);
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    `SF_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, st_reg != T_IDLE, !s_ready)
    `SF_ASSERT_IMP(a_lines_lockstep, aclk, aresetn, dl_done, dr_done)
    `SF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule
